>>> src/urtb_pkg.sv
// Shared types and constants for the UART receive/transmit ring buffers.
package urtb_pkg;

    localparam int CMD_W   = 3;
    localparam int BYTE_W  = 8;
    localparam int LEVEL_W = 7;

    // Event codes; the remaining code is a no-op
    typedef enum logic [CMD_W-1:0] {
        CMD_RX_BYTE  = 3'd0,
        CMD_HOST_PUT = 3'd1,
        CMD_TX_DONE  = 3'd2,
        CMD_HOST_GET = 3'd3,
        CMD_FLUSH_RX = 3'd4,
        CMD_FLUSH_TX = 3'd5,
        CMD_SET_EN   = 3'd6
    } t_cmd;

    // Ring control, one operation per transfer
    typedef struct packed {
        logic push;
        logic pop;
        logic flush;
    } t_ring_ctl;

    // Ring status
    typedef struct packed {
        logic empty;
        logic full;
        logic last;     // one free entry left
    } t_ring_sts;

endpackage

>>> src/urtb_ifs.sv
// Valid/ready channel interfaces for events and results.
interface urtb_in_if;
    logic                        valid;
    logic                        ready;
    logic [urtb_pkg::CMD_W-1:0]  command;
    logic [urtb_pkg::BYTE_W-1:0] data_byte;

    modport source (output valid, command, data_byte, input ready);
    modport sink   (input valid, command, data_byte, output ready);
endinterface

interface urtb_out_if;
    logic                         valid;
    logic                         ready;
    logic                         tx_valid;
    logic [urtb_pkg::BYTE_W-1:0]  tx_byte;
    logic                         rx_valid;
    logic [urtb_pkg::BYTE_W-1:0]  rx_byte;
    logic [urtb_pkg::LEVEL_W-1:0] rx_level;
    logic [urtb_pkg::LEVEL_W-1:0] tx_level;
    logic                         overflow_flag;
    logic                         receive_on;
    logic                         put_rejected;

    modport source (output valid, tx_valid, tx_byte, rx_valid, rx_byte, rx_level,
                     tx_level, overflow_flag, receive_on, put_rejected,
                     input ready);
    modport sink   (input valid, tx_valid, tx_byte, rx_valid, rx_byte, rx_level,
                     tx_level, overflow_flag, receive_on, put_rejected,
                     output ready);
endinterface

>>> src/urtb_ring.sv
// Byte ring buffer: synchronous memory plus head, tail and fill count.
module urtb_ring #(
    parameter int DEPTH = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  urtb_pkg::t_ring_ctl           i_ctl,
    input  logic [urtb_pkg::BYTE_W-1:0]   i_wr_data,
    output logic [urtb_pkg::BYTE_W-1:0]   o_rd_data,
    output logic [$clog2(DEPTH+1)-1:0]    o_fill,
    output urtb_pkg::t_ring_sts           o_sts
);

    localparam int PTR_W  = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(DEPTH);
    localparam logic [FILL_W-1:0] FILL_ONE = FILL_W'(1);

    logic [urtb_pkg::BYTE_W-1:0] r_mem [DEPTH];
    logic [urtb_pkg::BYTE_W-1:0] r_rd_data;
    logic [PTR_W-1:0]            r_head, n_head;
    logic [PTR_W-1:0]            r_tail, n_tail;
    logic [FILL_W-1:0]           r_fill, n_fill;

    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        n_fill = r_fill;
        if (i_ctl.flush) begin
            n_head = '0;
            n_tail = '0;
            n_fill = '0;
        end else if (i_ctl.push) begin
            n_head = (r_head == PTR_LAST) ? '0 : r_head + 1'b1;
            n_fill = r_fill + FILL_ONE;
        end else if (i_ctl.pop) begin
            n_tail = (r_tail == PTR_LAST) ? '0 : r_tail + 1'b1;
            n_fill = r_fill - FILL_ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_fill <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_fill <= n_fill;
        end
    end

    // Memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_ctl.push && !i_ctl.flush) begin
            r_mem[r_head] <= i_wr_data;
        end
        if (i_ctl.pop) begin
            r_rd_data <= r_mem[r_tail];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_fill    = r_fill;
    assign o_sts.empty = (r_fill == '0);
    assign o_sts.full  = (r_fill == FILL_MAX);
    assign o_sts.last  = (r_fill == FILL_MAX - FILL_ONE);

endmodule

>>> src/uart_rx_tx_ring_buffers_core.sv
// Top level: UART receive and transmit ring buffers driven by one event per transfer.
//
//  channel | dir | handshake        | payload
//  i_in    | in  | valid / ready    | command[2:0], data_byte[7:0]
//  o_out   | out | valid / ready    | tx_valid, tx_byte, rx_valid, rx_byte, rx_level,
//          |     |                  | tx_level, overflow_flag, receive_on, put_rejected
//
// Each event is handled in turn: the accept cycle updates pointers and flags and
// issues the ring memory access; ST_LOAD then picks up the registered read
// data and loads the result register. A new event is not accepted until the
// result of the last one is loaded, as the ring memories have a registered read port.
// A result waiting on o_out stalls ST_LOAD until the sink takes it.
// Reset clears pointers, fill counts and flags; the memories are not cleared.
module uart_rx_tx_ring_buffers_core #(
    parameter int RX_DEPTH = 64,
    parameter int TX_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    urtb_in_if.sink     i_in,
    urtb_out_if.source  o_out
);

    localparam int RX_FILL_W = $clog2(RX_DEPTH + 1);
    localparam int TX_FILL_W = $clog2(TX_DEPTH + 1);

    // One-hot sequencer
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_LOAD = 2'b10
    } t_state;

    t_state r_state, n_state;

    // Ring interfaces
    urtb_pkg::t_ring_ctl           rx_ctl, tx_ctl;
    urtb_pkg::t_ring_sts           rx_sts, tx_sts;
    logic [urtb_pkg::BYTE_W-1:0]   rx_rd_data, tx_rd_data;
    logic [RX_FILL_W-1:0]          rx_fill;
    logic [TX_FILL_W-1:0]          tx_fill;

    // Persistent flags
    logic r_rx_en, n_rx_en;
    logic r_ovf, n_ovf;
    logic r_tx_busy, n_tx_busy;

    // Per-event result info, captured at accept
    logic                        r_txv, n_txv;
    logic                        r_tx_mem, n_tx_mem;   // tx byte comes from the ring
    logic                        r_rxv, n_rxv;
    logic                        r_rej, n_rej;
    logic [urtb_pkg::BYTE_W-1:0] r_byte;

    // Result register
    logic                         r_out_valid;
    logic                         r_o_txv;
    logic [urtb_pkg::BYTE_W-1:0]  r_o_txb;
    logic                         r_o_rxv;
    logic [urtb_pkg::BYTE_W-1:0]  r_o_rxb;
    logic [urtb_pkg::LEVEL_W-1:0] r_o_rx_lvl;
    logic [urtb_pkg::LEVEL_W-1:0] r_o_tx_lvl;
    logic                         r_o_ovf;
    logic                         r_o_rx_en;
    logic                         r_o_rej;

    logic accept;
    logic load;
    logic [RX_FILL_W+urtb_pkg::LEVEL_W-1:0] rx_fill_ext;
    logic [TX_FILL_W+urtb_pkg::LEVEL_W-1:0] tx_fill_ext;
    urtb_pkg::t_cmd cmd;

    assign i_in.ready = (r_state == ST_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign cmd        = urtb_pkg::t_cmd'(i_in.command);

    urtb_ring #(.DEPTH(RX_DEPTH)) u_rx_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (rx_ctl),
        .i_wr_data (i_in.data_byte),
        .o_rd_data (rx_rd_data),
        .o_fill    (rx_fill),
        .o_sts     (rx_sts)
    );

    urtb_ring #(.DEPTH(TX_DEPTH)) u_tx_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (tx_ctl),
        .i_wr_data (i_in.data_byte),
        .o_rd_data (tx_rd_data),
        .o_fill    (tx_fill),
        .o_sts     (tx_sts)
    );

    // Event decode: ring operations and next flag values
    always_comb begin
        rx_ctl    = '0;
        tx_ctl    = '0;
        n_rx_en   = r_rx_en;
        n_ovf     = r_ovf;
        n_tx_busy = r_tx_busy;
        n_txv     = r_txv;
        n_tx_mem  = r_tx_mem;
        n_rxv     = r_rxv;
        n_rej     = r_rej;
        if (accept) begin
            n_txv    = 1'b0;
            n_tx_mem = 1'b0;
            n_rxv    = 1'b0;
            n_rej    = 1'b0;
            unique case (cmd)
                urtb_pkg::CMD_RX_BYTE: begin
                    if (r_rx_en) begin
                        if (rx_sts.full) begin
                            // re-enabled on a full ring: drop and shut off again
                            n_rx_en = 1'b0;
                            n_ovf   = 1'b1;
                        end else begin
                            rx_ctl.push = 1'b1;
                            if (rx_sts.last) begin
                                n_rx_en = 1'b0;
                                n_ovf   = 1'b1;
                            end
                        end
                    end
                end
                urtb_pkg::CMD_HOST_PUT: begin
                    if (tx_sts.full) begin
                        n_rej = 1'b1;
                    end else if (!tx_sts.empty || r_tx_busy) begin
                        tx_ctl.push = 1'b1;
                    end else begin
                        // straight to an idle transmitter
                        n_txv     = 1'b1;
                        n_tx_busy = 1'b1;
                    end
                end
                urtb_pkg::CMD_TX_DONE: begin
                    if (!tx_sts.empty) begin
                        tx_ctl.pop = 1'b1;
                        n_txv      = 1'b1;
                        n_tx_mem   = 1'b1;
                        n_tx_busy  = 1'b1;
                    end else begin
                        n_tx_busy = 1'b0;
                    end
                end
                urtb_pkg::CMD_HOST_GET: begin
                    if (!rx_sts.empty) begin
                        rx_ctl.pop = 1'b1;
                        n_rxv      = 1'b1;
                    end
                end
                urtb_pkg::CMD_FLUSH_RX: begin
                    rx_ctl.flush = 1'b1;
                    n_ovf        = 1'b0;
                end
                urtb_pkg::CMD_FLUSH_TX: begin
                    tx_ctl.flush = 1'b1;
                end
                urtb_pkg::CMD_SET_EN: begin
                    n_rx_en = i_in.data_byte[0];
                end
                default: begin
                end
            endcase
        end
    end

    // Sequencer: result loads once the output register is free
    assign load = (r_state == ST_LOAD) && (!r_out_valid || o_out.ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (accept) n_state = ST_LOAD;
            ST_LOAD: if (load)   n_state = ST_IDLE;
            default:             n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rx_en     <= 1'b0;
            r_ovf       <= 1'b0;
            r_tx_busy   <= 1'b0;
            r_txv       <= 1'b0;
            r_tx_mem    <= 1'b0;
            r_rxv       <= 1'b0;
            r_rej       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rx_en   <= n_rx_en;
            r_ovf     <= n_ovf;
            r_tx_busy <= n_tx_busy;
            r_txv     <= n_txv;
            r_tx_mem  <= n_tx_mem;
            r_rxv     <= n_rxv;
            r_rej     <= n_rej;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Fill counts reduced to the 7-bit level fields
    assign rx_fill_ext = {{urtb_pkg::LEVEL_W{1'b0}}, rx_fill};
    assign tx_fill_ext = {{urtb_pkg::LEVEL_W{1'b0}}, tx_fill};

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= i_in.data_byte;
        end
        if (load) begin
            r_o_txv    <= r_txv;
            r_o_txb    <= r_tx_mem ? tx_rd_data : (r_txv ? r_byte : '0);
            r_o_rxv    <= r_rxv;
            r_o_rxb    <= r_rxv ? rx_rd_data : '0;
            r_o_rx_lvl <= rx_fill_ext[urtb_pkg::LEVEL_W-1:0];
            r_o_tx_lvl <= tx_fill_ext[urtb_pkg::LEVEL_W-1:0];
            r_o_ovf    <= r_ovf;
            r_o_rx_en  <= r_rx_en;
            r_o_rej    <= r_rej;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.tx_valid      = r_o_txv;
    assign o_out.tx_byte       = r_o_txb;
    assign o_out.rx_valid      = r_o_rxv;
    assign o_out.rx_byte       = r_o_rxb;
    assign o_out.rx_level      = r_o_rx_lvl;
    assign o_out.tx_level      = r_o_tx_lvl;
    assign o_out.overflow_flag = r_o_ovf;
    assign o_out.receive_on    = r_o_rx_en;
    assign o_out.put_rejected  = r_o_rej;

    // A result appears only out of the load cycle
    a_out_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_LOAD))
        else $error("result shown without a load cycle");

    // One event hands over at most one of the two bytes
    a_one_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_o_txv && r_o_rxv))
        else $error("tx and rx bytes in the same result");

    // Overflow sets only on a received byte
    a_ovf_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovf) |-> $past(accept && (cmd == urtb_pkg::CMD_RX_BYTE)))
        else $error("overflow set by a non-receive event");

    // Fill counts stay within the ring depth
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rx_fill <= RX_FILL_W'(RX_DEPTH)) && (tx_fill <= TX_FILL_W'(TX_DEPTH)))
        else $error("ring fill beyond depth");

endmodule

>>> verif/testbench.sv
// Self-checking testbench for the UART receive/transmit ring buffer core.
`timescale 1ns / 1ps

module testbench;

    localparam int RX_DEPTH    = 64;
    localparam int TX_DEPTH    = 64;
    localparam int CYCLE_LIMIT = 200000;
    localparam int LIVE_EVENTS = 700;

    // Code 7 has no enum member; the core treats it as a no-op
    localparam logic [urtb_pkg::CMD_W-1:0] CMD_NOP = 3'd7;

    typedef struct packed {
        logic                         tx_valid;
        logic [urtb_pkg::BYTE_W-1:0]  tx_byte;
        logic                         rx_valid;
        logic [urtb_pkg::BYTE_W-1:0]  rx_byte;
        logic [urtb_pkg::LEVEL_W-1:0] rx_level;
        logic [urtb_pkg::LEVEL_W-1:0] tx_level;
        logic                         overflow_flag;
        logic                         receive_on;
        logic                         put_rejected;
    } t_uart_status;

    // One directed row: command, first data byte (incremented per repeat),
    // repeat count, and a hand-written status where it is obvious
    typedef struct packed {
        logic [urtb_pkg::CMD_W-1:0]  cmd;
        logic [urtb_pkg::BYTE_W-1:0] data;
        logic [6:0]                  reps;
        logic                        typed;
        t_uart_status                want;
    } t_plan_row;

    localparam int PLAN_LEN = 27;
    localparam t_plan_row PLAN [PLAN_LEN] = '{
        // get on empty ring, byte while disabled, done while idle
        '{urtb_pkg::CMD_HOST_GET, 8'h00, 7'd1, 1'b1,
          '{1'b0, 8'h00, 1'b0, 8'h00, 7'd0, 7'd0, 1'b0, 1'b0, 1'b0}},
        '{urtb_pkg::CMD_RX_BYTE,  8'hAA, 7'd1, 1'b1,
          '{1'b0, 8'h00, 1'b0, 8'h00, 7'd0, 7'd0, 1'b0, 1'b0, 1'b0}},
        '{urtb_pkg::CMD_TX_DONE,  8'h00, 7'd1, 1'b1,
          '{1'b0, 8'h00, 1'b0, 8'h00, 7'd0, 7'd0, 1'b0, 1'b0, 1'b0}},
        // put to idle transmitter goes straight out, then two queue up
        '{urtb_pkg::CMD_HOST_PUT, 8'hFF, 7'd1, 1'b1,
          '{1'b1, 8'hFF, 1'b0, 8'h00, 7'd0, 7'd0, 1'b0, 1'b0, 1'b0}},
        '{urtb_pkg::CMD_HOST_PUT, 8'h00, 7'd1, 1'b1,
          '{1'b0, 8'h00, 1'b0, 8'h00, 7'd0, 7'd1, 1'b0, 1'b0, 1'b0}},
        '{urtb_pkg::CMD_HOST_PUT, 8'hA5, 7'd1, 1'b1,
          '{1'b0, 8'h00, 1'b0, 8'h00, 7'd0, 7'd2, 1'b0, 1'b0, 1'b0}},
        '{urtb_pkg::CMD_TX_DONE,  8'h00, 7'd1, 1'b1,
          '{1'b1, 8'h00, 1'b0, 8'h00, 7'd0, 7'd1, 1'b0, 1'b0, 1'b0}},
        // flush tx keeps the byte in flight, so the next put queues
        '{urtb_pkg::CMD_FLUSH_TX, 8'h00, 7'd1, 1'b1,
          '{1'b0, 8'h00, 1'b0, 8'h00, 7'd0, 7'd0, 1'b0, 1'b0, 1'b0}},
        '{urtb_pkg::CMD_HOST_PUT, 8'h5A, 7'd1, 1'b1,
          '{1'b0, 8'h00, 1'b0, 8'h00, 7'd0, 7'd1, 1'b0, 1'b0, 1'b0}},
        // enable follows bit 0 only
        '{urtb_pkg::CMD_SET_EN,   8'hFE, 7'd1, 1'b1,
          '{1'b0, 8'h00, 1'b0, 8'h00, 7'd0, 7'd1, 1'b0, 1'b0, 1'b0}},
        '{urtb_pkg::CMD_SET_EN,   8'h01, 7'd1, 1'b1,
          '{1'b0, 8'h00, 1'b0, 8'h00, 7'd0, 7'd1, 1'b0, 1'b1, 1'b0}},
        '{urtb_pkg::CMD_RX_BYTE,  8'h00, 7'd1, 1'b1,
          '{1'b0, 8'h00, 1'b0, 8'h00, 7'd1, 7'd1, 1'b0, 1'b1, 1'b0}},
        '{urtb_pkg::CMD_RX_BYTE,  8'hFF, 7'd1, 1'b1,
          '{1'b0, 8'h00, 1'b0, 8'h00, 7'd2, 7'd1, 1'b0, 1'b1, 1'b0}},
        '{urtb_pkg::CMD_HOST_GET, 8'h00, 7'd1, 1'b1,
          '{1'b0, 8'h00, 1'b1, 8'h00, 7'd1, 7'd1, 1'b0, 1'b1, 1'b0}},
        '{urtb_pkg::CMD_FLUSH_RX, 8'h00, 7'd1, 1'b1,
          '{1'b0, 8'h00, 1'b0, 8'h00, 7'd0, 7'd1, 1'b0, 1'b1, 1'b0}},
        '{CMD_NOP,                8'h3C, 7'd1, 1'b1,
          '{1'b0, 8'h00, 1'b0, 8'h00, 7'd0, 7'd1, 1'b0, 1'b1, 1'b0}},
        // fill the receive ring: last byte sets overflow and drops enable
        '{urtb_pkg::CMD_RX_BYTE,  8'h10, 7'd64, 1'b0, '0},
        '{urtb_pkg::CMD_RX_BYTE,  8'h77, 7'd1, 1'b1,
          '{1'b0, 8'h00, 1'b0, 8'h00, 7'd64, 7'd1, 1'b1, 1'b0, 1'b0}},
        // re-enable on a full ring, next byte is dropped
        '{urtb_pkg::CMD_SET_EN,   8'h01, 7'd1, 1'b1,
          '{1'b0, 8'h00, 1'b0, 8'h00, 7'd64, 7'd1, 1'b1, 1'b1, 1'b0}},
        '{urtb_pkg::CMD_RX_BYTE,  8'h99, 7'd1, 1'b1,
          '{1'b0, 8'h00, 1'b0, 8'h00, 7'd64, 7'd1, 1'b1, 1'b0, 1'b0}},
        '{urtb_pkg::CMD_HOST_GET, 8'h00, 7'd64, 1'b0, '0},
        '{urtb_pkg::CMD_HOST_GET, 8'h00, 7'd1, 1'b1,
          '{1'b0, 8'h00, 1'b0, 8'h00, 7'd0, 7'd1, 1'b1, 1'b0, 1'b0}},
        '{urtb_pkg::CMD_FLUSH_RX, 8'h00, 7'd1, 1'b1,
          '{1'b0, 8'h00, 1'b0, 8'h00, 7'd0, 7'd1, 1'b0, 1'b0, 1'b0}},
        // fill the transmit queue, then one put too many
        '{urtb_pkg::CMD_HOST_PUT, 8'hC0, 7'd63, 1'b0, '0},
        '{urtb_pkg::CMD_HOST_PUT, 8'h33, 7'd1, 1'b1,
          '{1'b0, 8'h00, 1'b0, 8'h00, 7'd0, 7'd64, 1'b0, 1'b0, 1'b1}},
        // drain past empty so the transmitter goes idle
        '{urtb_pkg::CMD_TX_DONE,  8'h00, 7'd66, 1'b0, '0},
        '{urtb_pkg::CMD_TX_DONE,  8'h00, 7'd1, 1'b1,
          '{1'b0, 8'h00, 1'b0, 8'h00, 7'd0, 7'd0, 1'b0, 1'b0, 1'b0}}
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    urtb_in_if  ev_if ();
    urtb_out_if st_if ();

    uart_rx_tx_ring_buffers_core #(
        .RX_DEPTH (RX_DEPTH),
        .TX_DEPTH (TX_DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (ev_if),
        .o_out   (st_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of both rings
    logic [urtb_pkg::BYTE_W-1:0] rx_ring [RX_DEPTH];
    logic [urtb_pkg::BYTE_W-1:0] tx_ring [TX_DEPTH];
    int rx_wr, rx_rd, rx_count;
    int tx_wr, tx_rd, tx_count;
    bit rx_ovf, rx_en, tx_busy;

    t_uart_status status_due [$];
    int field_mismatches = 0;
    int event_count      = 0;   // events sent
    int cycles           = 0;
    int src_gap_pct      = 18;
    int sink_stall_pct   = 18;

    // Applies one event to the shadow rings and returns the status it reports
    function automatic t_uart_status advance_rings(logic [urtb_pkg::CMD_W-1:0] cmd,
                                                   logic [urtb_pkg::BYTE_W-1:0] data);
        t_uart_status s;
        s = '0;
        case (cmd)
            urtb_pkg::CMD_RX_BYTE: begin
                if (rx_en) begin
                    if (rx_count >= RX_DEPTH) begin
                        rx_en  = 1'b0;
                        rx_ovf = 1'b1;
                    end else begin
                        rx_ring[rx_wr] = data;
                        rx_wr = (rx_wr == RX_DEPTH - 1) ? 0 : rx_wr + 1;
                        rx_count++;
                        if (rx_count >= RX_DEPTH) begin
                            rx_en  = 1'b0;
                            rx_ovf = 1'b1;
                        end
                    end
                end
            end
            urtb_pkg::CMD_HOST_PUT: begin
                if (tx_count >= TX_DEPTH) begin
                    s.put_rejected = 1'b1;
                end else if (tx_count != 0 || tx_busy) begin
                    tx_ring[tx_wr] = data;
                    tx_wr = (tx_wr == TX_DEPTH - 1) ? 0 : tx_wr + 1;
                    tx_count++;
                end else begin
                    s.tx_valid = 1'b1;
                    s.tx_byte  = data;
                    tx_busy    = 1'b1;
                end
            end
            urtb_pkg::CMD_TX_DONE: begin
                if (tx_count != 0) begin
                    s.tx_valid = 1'b1;
                    s.tx_byte  = tx_ring[tx_rd];
                    tx_rd = (tx_rd == TX_DEPTH - 1) ? 0 : tx_rd + 1;
                    tx_count--;
                    tx_busy = 1'b1;
                end else begin
                    tx_busy = 1'b0;
                end
            end
            urtb_pkg::CMD_HOST_GET: begin
                if (rx_count != 0) begin
                    s.rx_valid = 1'b1;
                    s.rx_byte  = rx_ring[rx_rd];
                    rx_rd = (rx_rd == RX_DEPTH - 1) ? 0 : rx_rd + 1;
                    rx_count--;
                end
            end
            urtb_pkg::CMD_FLUSH_RX: begin
                rx_wr    = 0;
                rx_rd    = 0;
                rx_count = 0;
                rx_ovf   = 1'b0;
            end
            urtb_pkg::CMD_FLUSH_TX: begin
                tx_wr    = 0;
                tx_rd    = 0;
                tx_count = 0;
            end
            urtb_pkg::CMD_SET_EN: rx_en = data[0];
            default: ;
        endcase
        s.rx_level      = urtb_pkg::LEVEL_W'(rx_count);
        s.tx_level      = urtb_pkg::LEVEL_W'(tx_count);
        s.overflow_flag = rx_ovf;
        s.receive_on    = rx_en;
        return s;
    endfunction

    // Offers one event, waits for its transfer, then records what it should report
    task automatic send_event(logic [urtb_pkg::CMD_W-1:0] cmd,
                              logic [urtb_pkg::BYTE_W-1:0] data,
                              bit typed = 1'b0, t_uart_status want = '0);
        t_uart_status predicted;
        while ($urandom_range(99) < src_gap_pct) begin
            ev_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        ev_if.valid     <= 1'b1;
        ev_if.command   <= cmd;
        ev_if.data_byte <= data;
        @(posedge i_clk);
        while (!ev_if.ready) @(posedge i_clk);
        event_count++;
        predicted = advance_rings(cmd, data);
        status_due.push_back(typed ? want : predicted);
    endtask

    task automatic check_field(string fname, int want, int got);
        if (want != got) begin
            if (field_mismatches < 10)
                $display("mismatch on %s: expected %0d, got %0d", fname, want, got);
            field_mismatches++;
        end
    endtask

    task automatic take_status();
        t_uart_status want, got;
        got = '{st_if.tx_valid, st_if.tx_byte, st_if.rx_valid, st_if.rx_byte,
                st_if.rx_level, st_if.tx_level, st_if.overflow_flag,
                st_if.receive_on, st_if.put_rejected};
        if (status_due.size() == 0) begin
            if (field_mismatches < 10)
                $display("status transfer with nothing pending: %h", got);
            field_mismatches++;
        end else begin
            want = status_due.pop_front();
            check_field("tx_valid",      want.tx_valid,      got.tx_valid);
            check_field("tx_byte",       want.tx_byte,       got.tx_byte);
            check_field("rx_valid",      want.rx_valid,      got.rx_valid);
            check_field("rx_byte",       want.rx_byte,       got.rx_byte);
            check_field("rx_level",      want.rx_level,      got.rx_level);
            check_field("tx_level",      want.tx_level,      got.tx_level);
            check_field("overflow_flag", want.overflow_flag, got.overflow_flag);
            check_field("receive_on",    want.receive_on,    got.receive_on);
            check_field("put_rejected",  want.put_rejected,  got.put_rejected);
        end
    endtask

    // Status sink with random back-pressure
    initial begin
        st_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && st_if.valid && st_if.ready)
                take_status();
            st_if.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    initial begin
        logic [urtb_pkg::CMD_W-1:0] cmd;
        int  pick, n;
        bit  drained_once;
        drained_once    = 1'b0;
        ev_if.valid     = 1'b0;
        ev_if.command   = '0;
        ev_if.data_byte = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part
        foreach (PLAN[i])
            for (int r = 0; r < PLAN[i].reps; r++)
                send_event(PLAN[i].cmd, PLAN[i].data + 8'(r), PLAN[i].typed, PLAN[i].want);

        // Random part: episodes of mixed traffic plus fill and drain runs
        while (event_count < LIVE_EVENTS) begin
            // no idling on either side for a stretch
            if (event_count >= 350 && event_count < 500) begin
                src_gap_pct    = 0;
                sink_stall_pct = 0;
            end else begin
                src_gap_pct    = 18;
                sink_stall_pct = 18;
            end
            // hold off once until every pending status has come back
            if (!drained_once && event_count >= 560) begin
                ev_if.valid <= 1'b0;
                do @(posedge i_clk); while (status_due.size() != 0);
                drained_once = 1'b1;
            end
            case ($urandom_range(0, 11))
                6: begin
                    // fill rx to overflow, sometimes re-enable on the full ring
                    send_event(urtb_pkg::CMD_SET_EN, 8'($urandom) | 8'h01);
                    n = RX_DEPTH - rx_count + $urandom_range(0, 3);
                    repeat (n) begin
                        if ($urandom_range(0, 7) == 0)
                            send_event(urtb_pkg::CMD_HOST_GET, 8'($urandom));
                        else
                            send_event(urtb_pkg::CMD_RX_BYTE, 8'($urandom));
                    end
                    if ($urandom_range(0, 1) == 1) begin
                        send_event(urtb_pkg::CMD_SET_EN, 8'h01);
                        send_event(urtb_pkg::CMD_RX_BYTE, 8'($urandom));
                    end
                end
                7: begin
                    // fill the transmit queue past full
                    n = TX_DEPTH - tx_count + $urandom_range(1, 3);
                    repeat (n) begin
                        if ($urandom_range(0, 7) == 0)
                            send_event(urtb_pkg::CMD_TX_DONE, 8'($urandom));
                        else
                            send_event(urtb_pkg::CMD_HOST_PUT, 8'($urandom));
                    end
                end
                8: begin
                    n = rx_count + $urandom_range(0, 2);
                    repeat (n) send_event(urtb_pkg::CMD_HOST_GET, 8'($urandom));
                end
                9: begin
                    n = tx_count + $urandom_range(1, 2);
                    repeat (n) send_event(urtb_pkg::CMD_TX_DONE, 8'($urandom));
                end
                10, 11: begin
                    case ($urandom_range(0, 2))
                        0:       send_event(urtb_pkg::CMD_FLUSH_RX, 8'($urandom));
                        1:       send_event(urtb_pkg::CMD_FLUSH_TX, 8'($urandom));
                        default: send_event(urtb_pkg::CMD_SET_EN, 8'($urandom));
                    endcase
                end
                default: begin
                    if ($urandom_range(0, 3) == 0)
                        send_event(urtb_pkg::CMD_SET_EN, 8'($urandom) | 8'h01);
                    n = $urandom_range(5, 30);
                    repeat (n) begin
                        pick = $urandom_range(0, 19);
                        if (pick < 6)        cmd = urtb_pkg::CMD_RX_BYTE;
                        else if (pick < 10)  cmd = urtb_pkg::CMD_HOST_PUT;
                        else if (pick < 13)  cmd = urtb_pkg::CMD_TX_DONE;
                        else if (pick < 16)  cmd = urtb_pkg::CMD_HOST_GET;
                        else if (pick == 16) cmd = urtb_pkg::CMD_FLUSH_RX;
                        else if (pick == 17) cmd = urtb_pkg::CMD_FLUSH_TX;
                        else if (pick == 18) cmd = urtb_pkg::CMD_SET_EN;
                        else                 cmd = CMD_NOP;
                        send_event(cmd, 8'($urandom));
                    end
                end
            endcase
        end

        ev_if.valid <= 1'b0;
        while (status_due.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (field_mismatches == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
